FILE: hdl/text_line_number_escape_filter_assert.svh
// Assertion macros for the text line number and escape filter.
// Used by hdl/text_line_number_escape_filter.sv; expects clk and rst_n in scope.
`ifndef TEXT_LINE_NUMBER_ESCAPE_FILTER_ASSERT_SVH
`define TEXT_LINE_NUMBER_ESCAPE_FILTER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define TLNEF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked in the same cycle
`define TLNEF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle
`define TLNEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tlnef_pkg.sv
// Package for the text line number and escape filter: sizes, register
// indices, character codes and shared types. No dependencies.
package tlnef_pkg;

  // Columns of the printed line number
  localparam int NUM_DIGITS  = 6;
  // Number, tab, then at most four bytes for one rendered character
  localparam int TAIL_MAX    = 4;
  localparam int MAX_RESULTS = NUM_DIGITS + 1 + TAIL_MAX;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int TAIL_LEN_W  = $clog2(TAIL_MAX + 1);

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

  typedef logic [7:0] char_t;
  typedef logic [3:0] bcd_digit_t;
  typedef bcd_digit_t [NUM_DIGITS-1:0] line_num_t;

  // Character codes
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_NL     = 8'h0A;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_DOLLAR = 8'h24;
  localparam char_t CH_DASH   = 8'h2D;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_QMARK  = 8'h3F;
  localparam char_t CH_UPPER_I = 8'h49;
  localparam char_t CH_UPPER_M = 8'h4D;
  localparam char_t CH_CARET  = 8'h5E;
  localparam char_t CH_DEL    = 8'h7F;
  localparam char_t CH_HIGH_PRINT = 8'hA0;
  localparam char_t CH_HIGH_DEL   = 8'hFF;

  localparam bcd_digit_t BCD_NINE = 4'd9;

endpackage

FILE: hdl/text_line_number_escape_filter.sv
// Top level of the text line number and escape filter.
// Depends on tlnef_pkg and text_line_number_escape_filter_assert.svh.
//
// Takes one text byte per transaction and produces the bytes a cat-style filter
// prints for it, one per output transaction, with out_run_end marking the last
// byte of each input. The input byte is decoded in the cycle it is accepted:
// line number update, optional six-column number and tab, and the escaped
// rendering are built at once and loaded into a held record that shifts one
// byte per cycle into the output register while out_stall is low. An input
// yields 1 to 11 bytes, and the next input is taken in the cycle the last
// byte of the held record moves out, so single-byte traffic runs at one
// transaction per cycle while out_stall is low. A squeezed newline is accepted
// and produces nothing. The counter saturates at 999999. Configuration
// writes are always ready and take effect from the next accepted byte.
module text_line_number_escape_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  // input byte stream
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tlnef_pkg::char_t               in_byte,
  // formatted output stream
  output logic                           out_valid,
  input  logic                           out_stall,
  output tlnef_pkg::char_t               out_byte,
  output logic                           out_run_end,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlnef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data
);
  import tlnef_pkg::*;

`include "text_line_number_escape_filter_assert.svh"

  // Mode registers
  logic number_nonblank_r, number_all_r, squeeze_blank_r;
  logic show_tabs_r, show_ends_r, show_nonprinting_r;

  // Stream state
  line_num_t  line_number_r, line_number_nxt;
  logic       number_printed_r, number_printed_nxt;
  logic [1:0] newline_run_r, newline_run_nxt;

  // Held record and output register
  char_t [MAX_RESULTS-1:0] rec_bytes_r, rec_bytes_nxt;
  logic [CNT_W-1:0]        rec_cnt_r, rec_cnt_nxt;
  logic                    rec_valid_r, rec_valid_nxt;
  logic                    out_valid_r, out_valid_nxt;
  char_t                   out_byte_r, out_byte_nxt;
  logic                    out_run_end_r, out_run_end_nxt;

  // Decode signals
  logic                    in_accept, rec_move, rec_last;
  logic                    is_nl, squeeze, do_print;
  line_num_t               line_inc;
  char_t [NUM_DIGITS-1:0]  num_chars;
  char_t [TAIL_MAX-1:0]    tail;
  logic [TAIL_LEN_W-1:0]   tail_len;
  char_t [MAX_RESULTS-1:0] new_bytes;
  logic [CNT_W-1:0]        new_cnt;
  logic                    bcd_ok;

  // Handshakes
  assign cfg_ready   = 1'b1;
  assign rec_move    = rec_valid_r && (!out_valid_r || !out_stall);
  assign rec_last    = (rec_cnt_r == CNT_W'(1));
  assign in_stall    = rec_valid_r && !(rec_move && rec_last);
  assign in_accept   = in_valid && !in_stall;
  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_run_end = out_run_end_r;

  // Squeeze and numbering decisions
  assign is_nl    = (in_byte == CH_NL);
  assign squeeze  = (newline_run_r == 2'd2) && squeeze_blank_r && is_nl;
  assign do_print = !number_printed_r && (number_nonblank_r ? !is_nl : number_all_r);

  // Saturating BCD increment of the line counter
  always_comb begin
    logic carry;
    logic all_nines;
    carry     = 1'b1;
    all_nines = 1'b1;
    line_inc  = line_number_r;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      all_nines = all_nines && (line_number_r[i] == BCD_NINE);
      if (carry) begin
        if (line_number_r[i] == BCD_NINE) begin
          line_inc[i] = '0;
        end else begin
          line_inc[i] = line_number_r[i] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    if (all_nines) begin
      line_inc = line_number_r;
    end
  end

  // Right-aligned digits, leading zeros shown as spaces
  always_comb begin
    logic lead;
    lead = 1'b1;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      lead = lead && (line_inc[i] == '0);
      num_chars[NUM_DIGITS-1-i] = lead ? CH_SPACE : (CH_ZERO + {4'd0, line_inc[i]});
    end
  end

  // Rendering of the byte itself
  always_comb begin
    tail     = '0;
    tail_len = TAIL_LEN_W'(1);
    tail[0]  = in_byte;
    if (show_tabs_r && (in_byte == CH_TAB)) begin
      tail[0]  = CH_CARET;
      tail[1]  = CH_UPPER_I;
      tail_len = TAIL_LEN_W'(2);
    end else if (is_nl) begin
      if (show_ends_r) begin
        tail[0]  = CH_DOLLAR;
        tail[1]  = CH_NL;
        tail_len = TAIL_LEN_W'(2);
      end
    end else if (show_nonprinting_r) begin
      if ((in_byte == CH_TAB) || ((in_byte >= CH_SPACE) && (in_byte < CH_DEL))) begin
        tail[0] = in_byte;
      end else if (in_byte == CH_DEL) begin
        tail[0]  = CH_CARET;
        tail[1]  = CH_QMARK;
        tail_len = TAIL_LEN_W'(2);
      end else if (in_byte == CH_HIGH_DEL) begin
        tail[0]  = CH_UPPER_M;
        tail[1]  = CH_DASH;
        tail[2]  = CH_CARET;
        tail[3]  = CH_QMARK;
        tail_len = TAIL_LEN_W'(4);
      end else if (in_byte >= CH_HIGH_PRINT) begin
        tail[0]  = CH_UPPER_M;
        tail[1]  = CH_DASH;
        tail[2]  = in_byte - 8'd128;
        tail_len = TAIL_LEN_W'(3);
      end else if (in_byte[7]) begin
        // high control byte
        tail[0]  = CH_UPPER_M;
        tail[1]  = CH_DASH;
        tail[2]  = CH_CARET;
        tail[3]  = in_byte - 8'd64;
        tail_len = TAIL_LEN_W'(4);
      end else begin
        // low control byte
        tail[0]  = CH_CARET;
        tail[1]  = in_byte + 8'd64;
        tail_len = TAIL_LEN_W'(2);
      end
    end
  end

  // Assemble the record for this input
  always_comb begin
    new_bytes = '0;
    if (do_print) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        new_bytes[i] = num_chars[i];
      end
      new_bytes[NUM_DIGITS] = CH_TAB;
      for (int k = 0; k < TAIL_MAX; k++) begin
        new_bytes[NUM_DIGITS+1+k] = tail[k];
      end
      new_cnt = CNT_W'(NUM_DIGITS + 1) + CNT_W'(tail_len);
    end else begin
      for (int k = 0; k < TAIL_MAX; k++) begin
        new_bytes[k] = tail[k];
      end
      new_cnt = CNT_W'(tail_len);
    end
    if (squeeze) begin
      new_cnt = '0;
    end
  end

  // Next stream state
  always_comb begin
    line_number_nxt    = line_number_r;
    number_printed_nxt = number_printed_r;
    newline_run_nxt    = newline_run_r;
    if (in_accept && !squeeze) begin
      if (do_print) begin
        line_number_nxt = line_inc;
      end
      if (number_nonblank_r || number_all_r) begin
        number_printed_nxt = !is_nl;
      end
      if (is_nl) begin
        newline_run_nxt = (newline_run_r == 2'd2) ? 2'd2 : newline_run_r + 2'd1;
      end else begin
        newline_run_nxt = 2'd0;
      end
    end
  end

  // Record shift and output register
  always_comb begin
    rec_bytes_nxt   = rec_bytes_r;
    rec_cnt_nxt     = rec_cnt_r;
    rec_valid_nxt   = rec_valid_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_byte_nxt    = out_byte_r;
    out_run_end_nxt = out_run_end_r;
    if (rec_move) begin
      out_valid_nxt   = 1'b1;
      out_byte_nxt    = rec_bytes_r[0];
      out_run_end_nxt = rec_last;
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        rec_bytes_nxt[i] = rec_bytes_r[i+1];
      end
      rec_cnt_nxt   = rec_cnt_r - CNT_W'(1);
      rec_valid_nxt = !rec_last;
    end
    if (in_accept && (new_cnt != '0)) begin
      rec_bytes_nxt = new_bytes;
      rec_cnt_nxt   = new_cnt;
      rec_valid_nxt = 1'b1;
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_nonblank_r  <= 1'b0;
      number_all_r       <= 1'b0;
      squeeze_blank_r    <= 1'b0;
      show_tabs_r        <= 1'b0;
      show_ends_r        <= 1'b0;
      show_nonprinting_r <= 1'b0;
      line_number_r      <= '0;
      number_printed_r   <= 1'b0;
      newline_run_r      <= 2'd0;
      rec_cnt_r          <= '0;
      rec_valid_r        <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_NUMBER_NONBLANK:  number_nonblank_r  <= cfg_data;
          REG_NUMBER_ALL:       number_all_r       <= cfg_data;
          REG_SQUEEZE_BLANK:    squeeze_blank_r    <= cfg_data;
          REG_SHOW_TABS:        show_tabs_r        <= cfg_data;
          REG_SHOW_ENDS:        show_ends_r        <= cfg_data;
          REG_SHOW_NONPRINTING: show_nonprinting_r <= cfg_data;
          default: ;
        endcase
      end
      line_number_r    <= line_number_nxt;
      number_printed_r <= number_printed_nxt;
      newline_run_r    <= newline_run_nxt;
      rec_cnt_r        <= rec_cnt_nxt;
      rec_valid_r      <= rec_valid_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    rec_bytes_r   <= rec_bytes_nxt;
    out_byte_r    <= out_byte_nxt;
    out_run_end_r <= out_run_end_nxt;
  end

  // Every counter digit stays a decimal digit
  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_ok = bcd_ok && (line_number_r[i] <= BCD_NINE);
    end
  end

  `TLNEF_ASSERT_ALWAYS(a_bcd_digits, bcd_ok,
    "line counter holds a non-decimal digit")
  `TLNEF_ASSERT_NOW(a_rec_count, rec_valid_r,
    (rec_cnt_r != '0) && (rec_cnt_r <= CNT_W'(MAX_RESULTS)),
    "held record count out of range")
  `TLNEF_ASSERT_NOW(a_run_pending, out_valid_r && !out_run_end_r, rec_valid_r,
    "output byte not last but record empty")
  `TLNEF_ASSERT_NEXT(a_squeeze_hold, in_accept && squeeze,
    $stable(line_number_r) && $stable(newline_run_r),
    "squeezed newline changed state")

endmodule

FILE: dv/tb.sv
// Self-checking testbench for text_line_number_escape_filter.
// Needs tlnef_pkg and the RTL top level. A behavioural predictor of the filter, or
// the output typed into a directed row, supplies the expected text, compared byte by byte.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlnef_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LINE_MAX      = 10 ** NUM_DIGITS - 1;
  localparam int SETS_PER_PHASE = 4;
  localparam int BYTES_PER_SET  = 10;

  // Offsets used by caret and M- notation
  localparam char_t HIGH_BIT    = 8'h80;
  localparam char_t CTRL_OFFSET = 8'h40;

  // Mode word: bit i is configuration register i
  localparam logic [5:0] M_NONBLANK = 6'd1 << REG_NUMBER_NONBLANK;
  localparam logic [5:0] M_ALL      = 6'd1 << REG_NUMBER_ALL;
  localparam logic [5:0] M_SQUEEZE  = 6'd1 << REG_SQUEEZE_BLANK;
  localparam logic [5:0] M_TABS     = 6'd1 << REG_SHOW_TABS;
  localparam logic [5:0] M_ENDS     = 6'd1 << REG_SHOW_ENDS;
  localparam logic [5:0] M_NONPRINT = 6'd1 << REG_SHOW_NONPRINTING;

  typedef struct packed {
    char_t text;
    logic  last;
  } out_char_t;

  // One line of the directed table: a mode change or an input byte, the
  // latter with its output typed in where it is obvious
  typedef struct packed {
    logic            is_cfg;
    logic [5:0]      mode;
    char_t           data;
    logic            typed;
    logic [2:0]      n_exp;
    char_t [3:0]     exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  char_t in_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  char_t out_byte;
  logic out_run_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic cfg_data = 1'b0;

  // Predictor state and mode copy
  logic [5:0] mode = '0;
  int line_count = 0;
  logic num_printed = 1'b0;
  int nl_run = 0;

  char_t render_buf[$];
  out_char_t expected_text[$];
  stim_row_t directed_rows[$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  text_line_number_escape_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_run_end(out_run_end),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each output transaction with the oldest expected byte
  always @(posedge clk) begin : check_out
    out_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        errors++;
        $display("%0t: unexpected output: expected nothing, got byte %h run_end %b",
                 $time, out_byte, out_run_end);
      end else begin
        want = expected_text.pop_front();
        if (out_byte !== want.text) begin
          errors++;
          $display("%0t: out_byte expected %h, got %h", $time, want.text, out_byte);
        end
        if (out_run_end !== want.last) begin
          errors++;
          $display("%0t: out_run_end expected %b, got %b", $time, want.last, out_run_end);
        end
      end
    end
  end

  // Six-column right-aligned line number and a tab
  function automatic void render_number();
    char_t digs [NUM_DIGITS];
    int v;
    if (line_count < LINE_MAX) line_count++;
    v = line_count;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      if (v != 0) begin
        digs[i] = CH_ZERO + char_t'(v % 10);
        v = v / 10;
      end else begin
        digs[i] = CH_SPACE;
      end
    end
    for (int i = 0; i < NUM_DIGITS; i++) render_buf.push_back(digs[i]);
    render_buf.push_back(CH_TAB);
    num_printed = 1'b1;
  endfunction

  // Output text for one input byte; leaves render_buf empty when squeezed
  function automatic void filter_byte(input char_t b);
    char_t c;
    logic nl;
    c = b;
    nl = (b == CH_NL);
    render_buf.delete();
    if (nl_run == 2 && mode[REG_SQUEEZE_BLANK] && nl) return;

    // Line numbering; number-nonblank wins over number-all
    if (mode[REG_NUMBER_NONBLANK]) begin
      if (!nl) begin
        if (!num_printed) render_number();
      end else begin
        num_printed = 1'b0;
      end
    end else if (mode[REG_NUMBER_ALL]) begin
      if (!num_printed) render_number();
      if (nl) num_printed = 1'b0;
    end

    if (mode[REG_SHOW_TABS] && c == CH_TAB) begin
      render_buf.push_back(CH_CARET);
      c = CH_UPPER_I;
    end

    if (nl) begin
      if (mode[REG_SHOW_ENDS]) render_buf.push_back(CH_DOLLAR);
      if (nl_run < 2) nl_run++;
    end else begin
      nl_run = 0;
    end

    // Caret and M- notation
    if (!mode[REG_SHOW_NONPRINTING]) begin
      render_buf.push_back(c);
    end else if (c == CH_TAB || c == CH_NL || (c >= CH_SPACE && c < CH_DEL)) begin
      render_buf.push_back(c);
    end else if (c == CH_DEL) begin
      render_buf.push_back(CH_CARET);
      render_buf.push_back(CH_QMARK);
    end else if (c >= CH_HIGH_PRINT) begin
      render_buf.push_back(CH_UPPER_M);
      render_buf.push_back(CH_DASH);
      if (c < CH_HIGH_DEL) begin
        render_buf.push_back(c - HIGH_BIT);
      end else begin
        render_buf.push_back(CH_CARET);
        render_buf.push_back(CH_QMARK);
      end
    end else if (c >= HIGH_BIT) begin
      render_buf.push_back(CH_UPPER_M);
      render_buf.push_back(CH_DASH);
      render_buf.push_back(CH_CARET);
      render_buf.push_back(c - CTRL_OFFSET);
    end else begin
      render_buf.push_back(CH_CARET);
      render_buf.push_back(c + CTRL_OFFSET);
    end
  endfunction

  function automatic stim_row_t cfg_row(input logic [5:0] m);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.mode = m;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input char_t b, input logic [2:0] n,
                                          input char_t e0 = '0, input char_t e1 = '0,
                                          input char_t e2 = '0, input char_t e3 = '0);
    stim_row_t r;
    r = '0;
    r.data = b;
    r.typed = 1'b1;
    r.n_exp = n;
    r.exp[0] = e0;
    r.exp[1] = e1;
    r.exp[2] = e2;
    r.exp[3] = e3;
    return r;
  endfunction

  function automatic stim_row_t pred_row(input char_t b);
    stim_row_t r;
    r = '0;
    r.data = b;
    return r;
  endfunction

  // Mostly text: newlines, tabs and printable bytes, with some raw bytes
  function automatic char_t random_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 22) return CH_NL;
    if (r < 32) return CH_TAB;
    if (r < 75) return char_t'($urandom_range(32, 126));
    return char_t'($urandom_range(0, 255));
  endfunction

  // Drive one byte, wait for the transaction and queue its expected text
  task automatic send_byte(input char_t b, input logic typed, input logic [2:0] n,
                           input char_t [3:0] e);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    filter_byte(b);
    if (typed) begin
      for (int k = 0; k < n; k++) expected_text.push_back('{e[k], k == n - 1});
    end else begin
      foreach (render_buf[k])
        expected_text.push_back('{render_buf[k], k == render_buf.size() - 1});
    end
  endtask

  // Stop sending and let all output text drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every register from a mode word, valid held across the burst
  task automatic apply_mode(input logic [5:0] m);
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= m[i];
      do @(posedge clk); while (!cfg_ready);
      mode[i] = m[i];
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    // Stream start, run count saturation, plain mode, escapes, numbering
    directed_rows.push_back(cfg_row(M_SQUEEZE));
    directed_rows.push_back(typed_row(CH_NL, 1, CH_NL));
    directed_rows.push_back(typed_row(CH_NL, 1, CH_NL));
    directed_rows.push_back(typed_row(CH_NL, 0));
    directed_rows.push_back(cfg_row('0));
    directed_rows.push_back(typed_row(CH_NL, 1, CH_NL));
    directed_rows.push_back(cfg_row(M_SQUEEZE));
    directed_rows.push_back(typed_row(CH_NL, 0));
    directed_rows.push_back(cfg_row('0));
    directed_rows.push_back(typed_row(8'h41, 1, 8'h41));
    directed_rows.push_back(typed_row(8'h00, 1, 8'h00));
    directed_rows.push_back(typed_row(8'hFF, 1, 8'hFF));
    directed_rows.push_back(typed_row(CH_TAB, 1, CH_TAB));
    directed_rows.push_back(cfg_row(M_NONPRINT));
    directed_rows.push_back(typed_row(8'h00, 2, CH_CARET, 8'h40));
    directed_rows.push_back(typed_row(8'h1F, 2, CH_CARET, 8'h5F));
    directed_rows.push_back(typed_row(8'h7E, 1, 8'h7E));
    directed_rows.push_back(typed_row(CH_DEL, 2, CH_CARET, CH_QMARK));
    directed_rows.push_back(typed_row(8'h80, 4, CH_UPPER_M, CH_DASH, CH_CARET, 8'h40));
    directed_rows.push_back(typed_row(8'h9F, 4, CH_UPPER_M, CH_DASH, CH_CARET, 8'h5F));
    directed_rows.push_back(typed_row(CH_HIGH_PRINT, 3, CH_UPPER_M, CH_DASH, CH_SPACE));
    directed_rows.push_back(typed_row(8'hFE, 3, CH_UPPER_M, CH_DASH, 8'h7E));
    directed_rows.push_back(typed_row(CH_HIGH_DEL, 4, CH_UPPER_M, CH_DASH, CH_CARET,
                                      CH_QMARK));
    directed_rows.push_back(cfg_row(M_NONPRINT | M_TABS));
    directed_rows.push_back(typed_row(CH_TAB, 2, CH_CARET, CH_UPPER_I));
    directed_rows.push_back(cfg_row(M_NONPRINT | M_TABS | M_ENDS));
    directed_rows.push_back(typed_row(CH_NL, 2, CH_DOLLAR, CH_NL));
    directed_rows.push_back(cfg_row(M_NONPRINT | M_TABS | M_ENDS | M_ALL));
    directed_rows.push_back(pred_row(8'h78));
    directed_rows.push_back(pred_row(CH_NL));
    directed_rows.push_back(pred_row(CH_NL));
    directed_rows.push_back(cfg_row(M_NONPRINT | M_TABS | M_ENDS | M_ALL | M_NONBLANK));
    directed_rows.push_back(pred_row(CH_NL));
    directed_rows.push_back(pred_row(8'h79));
    directed_rows.push_back(pred_row(CH_NL));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    send_idle_pct = 11;
    recv_stall_pct = 58;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        apply_mode(directed_rows[i].mode);
      end else begin
        send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].n_exp,
                  directed_rows[i].exp);
      end
    end

    // Random text under three idling schemes and a range of modes
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 11 : (p == 1) ? 58 : 0;
      recv_stall_pct = (p == 0) ? 58 : (p == 1) ? 11 : 0;
      for (int s = 0; s < SETS_PER_PHASE; s++) begin
        wait_idle();
        if (s == 0)
          apply_mode((p == 0) ? 6'h3F : (p == 1) ? 6'h00 :
                     (M_ALL | M_TABS | M_ENDS | M_NONPRINT | M_SQUEEZE));
        else
          apply_mode(6'($urandom_range(0, 63)));
        for (int k = 0; k < BYTES_PER_SET; k++)
          send_byte(random_text_byte(), 1'b0, '0, '0);
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
